FILE: rtl/qclt_pkg.sv
// Shared types and constants for the quoted command-line tokenizer.
`timescale 1ns / 1ps

package qclt_pkg;

  localparam int LINE_BYTES_DEF = 255;
  localparam int RES_MAX        = 3;
  localparam int RQ_DEPTH       = 4;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_DOUBLE = 2'd1,
    Q_SINGLE = 2'd2
  } quote_t;

  typedef enum logic [1:0] {
    K_CHAR    = 2'd0,
    K_END     = 2'd1,
    K_SUMMARY = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t  item_kind;
    logic [7:0]  token_char;
    logic [7:0]  token_number;
    logic [7:0]  char_offset;
    logic [7:0]  cursor_token;
    logic [7:0]  cursor_offset;
    logic        cursor_placed;
    logic        run_last;
  } res_t;

endpackage

FILE: rtl/qclt_core.sv
// Per-byte tokenizer state update and result generation.
`timescale 1ns / 1ps

module qclt_core
  import qclt_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [7:0]           line_byte,
  input  logic                 byte_present,
  input  logic                 line_last,
  input  logic [7:0]           cursor_position,
  output logic [RES_MAX-1:0]   push_vld,
  output res_t [RES_MAX-1:0]   push_item
);

  localparam int IW = $clog2(LINE_BYTES + 1);
  localparam int CW = (IW > 8) ? IW : 8;

  function automatic logic [7:0] sat8(input logic [CW-1:0] v);
    logic [7:0] r;
    r = (v > CW'(255)) ? 8'hFF : v[7:0];
    return r;
  endfunction

  quote_t        open_quote_r, open_quote_nxt;
  quote_t        closed_quote_r, closed_quote_nxt;
  logic [CW-1:0] tok_len_r, tok_len_nxt;
  logic [CW-1:0] tok_cnt_r, tok_cnt_nxt;
  logic [CW-1:0] byte_index_r, byte_index_nxt;
  logic [7:0]    last_len_r, last_len_nxt;
  logic [7:0]    seen_tok_r, seen_tok_nxt;
  logic [7:0]    seen_off_r, seen_off_nxt;
  logic          hit_r, hit_nxt;

  quote_t        q;
  logic          in_range;
  logic          do_char;
  logic          space_end;
  logic          do_end;
  logic          mark;
  logic [CW-1:0] len1;
  logic [CW-1:0] cnt2;
  logic [CW-1:0] idx1;
  logic [CW-1:0] cur_w;
  logic [7:0]    len2;
  logic [7:0]    sum_tok;
  logic [7:0]    sum_off;
  logic          sum_placed;

  always_comb begin
    q = Q_NONE;
    if (line_byte == CH_DQUOTE) begin
      q = Q_DOUBLE;
    end else if (line_byte == CH_SQUOTE) begin
      q = Q_SINGLE;
    end
    cur_w     = CW'(cursor_position);
    in_range  = byte_present && (byte_index_r < CW'(LINE_BYTES));
    do_char   = 1'b0;
    space_end = 1'b0;
    open_quote_nxt   = open_quote_r;
    closed_quote_nxt = closed_quote_r;
    if (in_range) begin
      if (open_quote_r != Q_NONE && open_quote_r != q) begin
        do_char = 1'b1;
      end else if (open_quote_r != Q_NONE) begin
        closed_quote_nxt = open_quote_r;
        open_quote_nxt   = Q_NONE;
      end else if (q != Q_NONE) begin
        if (closed_quote_r == q) begin
          do_char = 1'b1;
        end
        open_quote_nxt = q;
      end else begin
        closed_quote_nxt = Q_NONE;
        if (line_byte == CH_SPACE) begin
          space_end = 1'b1;
        end else begin
          do_char = 1'b1;
        end
      end
    end

    mark   = do_char && (cur_w == byte_index_r);
    len1   = tok_len_r + CW'(do_char);
    do_end = (space_end || line_last) && (len1 != '0);
    cnt2   = tok_cnt_r + CW'(do_end);
    len2   = do_end ? sat8(len1) : last_len_r;
    idx1   = byte_index_r + CW'(in_range);

    hit_nxt      = hit_r || mark;
    seen_tok_nxt = mark ? sat8(tok_cnt_r) : seen_tok_r;
    seen_off_nxt = mark ? sat8(tok_len_r) : seen_off_r;

    if (cur_w >= idx1) begin
      sum_tok    = (cnt2 == '0) ? 8'd0 : sat8(cnt2 - CW'(1));
      sum_off    = (cnt2 == '0) ? 8'd0 : len2;
      sum_placed = 1'b1;
    end else if (hit_nxt) begin
      sum_tok    = seen_tok_nxt;
      sum_off    = seen_off_nxt;
      sum_placed = 1'b1;
    end else begin
      sum_tok    = 8'd0;
      sum_off    = 8'd0;
      sum_placed = 1'b0;
    end

    tok_len_nxt    = do_end ? '0 : len1;
    tok_cnt_nxt    = cnt2;
    byte_index_nxt = idx1;
    last_len_nxt   = len2;
    if (line_last) begin
      open_quote_nxt   = Q_NONE;
      closed_quote_nxt = Q_NONE;
      tok_len_nxt      = '0;
      tok_cnt_nxt      = '0;
      byte_index_nxt   = '0;
      last_len_nxt     = 8'd0;
      seen_tok_nxt     = 8'd0;
      seen_off_nxt     = 8'd0;
      hit_nxt          = 1'b0;
    end
  end

  always_comb begin
    push_vld = {acc && line_last, acc && do_end, acc && do_char};

    push_item[0].item_kind     = K_CHAR;
    push_item[0].token_char    = line_byte;
    push_item[0].token_number  = sat8(tok_cnt_r);
    push_item[0].char_offset   = sat8(tok_len_r);
    push_item[0].cursor_token  = 8'd0;
    push_item[0].cursor_offset = 8'd0;
    push_item[0].cursor_placed = 1'b0;
    push_item[0].run_last      = !do_end && !line_last;

    push_item[1].item_kind     = K_END;
    push_item[1].token_char    = 8'd0;
    push_item[1].token_number  = sat8(tok_cnt_r);
    push_item[1].char_offset   = sat8(len1);
    push_item[1].cursor_token  = 8'd0;
    push_item[1].cursor_offset = 8'd0;
    push_item[1].cursor_placed = 1'b0;
    push_item[1].run_last      = !line_last;

    push_item[2].item_kind     = K_SUMMARY;
    push_item[2].token_char    = 8'd0;
    push_item[2].token_number  = sat8(cnt2);
    push_item[2].char_offset   = 8'd0;
    push_item[2].cursor_token  = sum_tok;
    push_item[2].cursor_offset = sum_off;
    push_item[2].cursor_placed = sum_placed;
    push_item[2].run_last      = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_quote_r   <= Q_NONE;
      closed_quote_r <= Q_NONE;
      tok_len_r      <= '0;
      tok_cnt_r      <= '0;
      byte_index_r   <= '0;
      last_len_r     <= 8'd0;
      seen_tok_r     <= 8'd0;
      seen_off_r     <= 8'd0;
      hit_r          <= 1'b0;
    end else if (acc) begin
      open_quote_r   <= open_quote_nxt;
      closed_quote_r <= closed_quote_nxt;
      tok_len_r      <= tok_len_nxt;
      tok_cnt_r      <= tok_cnt_nxt;
      byte_index_r   <= byte_index_nxt;
      last_len_r     <= last_len_nxt;
      seen_tok_r     <= seen_tok_nxt;
      seen_off_r     <= seen_off_nxt;
      hit_r          <= hit_nxt;
    end
  end

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= CW'(LINE_BYTES))
    else $error("byte index past line limit");

  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && line_last |=> byte_index_r == '0 && tok_cnt_r == '0 && !hit_r)
    else $error("line state not cleared after summary");

  a_len_le_index: assert property (@(posedge clk) disable iff (!rst_n)
    tok_len_r <= byte_index_r)
    else $error("token length exceeds bytes seen");

endmodule

FILE: rtl/qclt_resq.sv
// Result queue: takes up to three results per beat, hands out one per beat while pop_stall is low.
`timescale 1ns / 1ps

module qclt_resq
  import qclt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [RES_MAX-1:0] push_vld,
  input  res_t [RES_MAX-1:0] push_item,
  input  logic               pop_stall,
  output logic               room,
  output logic               head_vld,
  output res_t               head
);

  localparam int PTR_W = $clog2(RQ_DEPTH);
  localparam int CNT_W = $clog2(RQ_DEPTH + 1);

  res_t             mem [RQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] pos [RES_MAX];
  logic [CNT_W-1:0] n_push;
  logic             pop;

  always_comb begin
    pos[0] = '0;
    pos[1] = PTR_W'(push_vld[0]);
    pos[2] = PTR_W'(push_vld[0]) + PTR_W'(push_vld[1]);
    n_push = CNT_W'(push_vld[0]) + CNT_W'(push_vld[1]) + CNT_W'(push_vld[2]);
    head_vld   = count_r != '0;
    head       = mem[rd_ptr_r];
    pop        = head_vld && !pop_stall;
    room       = count_r <= CNT_W'(RQ_DEPTH - RES_MAX);
    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + n_push - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (push_vld[i]) begin
        mem[wr_ptr_r + pos[i]] <= push_item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RQ_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (|push_vld) |-> room)
    else $error("push without room");

  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    head_vld && pop_stall |=> head_vld && $stable(head))
    else $error("stalled head beat changed");

endmodule

FILE: rtl/quoted_command_line_tokenizer.sv
// Top level: quoted command-line tokenizer with result queue.
// Each accepted beat's results are registered in the queue and offered on out_.
// Throughput: one input beat per cycle while each beat gives at most one result
// and out_stall is low; a beat giving two or three results holds the input until
// the single result port has drained the four-entry result queue to one entry.
// Reset: synchronous active-low rst_n clears line state and empties the queue.
`timescale 1ns / 1ps

module quoted_command_line_tokenizer
  import qclt_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_line_byte,
  input  logic       in_byte_present,
  input  logic       in_line_last,
  input  logic [7:0] in_cursor_position,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_item_kind,
  output logic [7:0] out_token_char,
  output logic [7:0] out_token_number,
  output logic [7:0] out_char_offset,
  output logic [7:0] out_cursor_token,
  output logic [7:0] out_cursor_offset,
  output logic       out_cursor_placed,
  output logic       out_run_last
);

  logic               room;
  logic               acc;
  logic [RES_MAX-1:0] push_vld;
  res_t [RES_MAX-1:0] push_item;
  res_t               head;

  assign in_stall = !room;
  assign acc      = in_valid && room;

  qclt_core #(
    .LINE_BYTES(LINE_BYTES)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .line_byte      (in_line_byte),
    .byte_present   (in_byte_present),
    .line_last      (in_line_last),
    .cursor_position(in_cursor_position),
    .push_vld       (push_vld),
    .push_item      (push_item)
  );

  qclt_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_vld (push_vld),
    .push_item(push_item),
    .pop_stall(out_stall),
    .room     (room),
    .head_vld (out_valid),
    .head     (head)
  );

  assign out_item_kind     = head.item_kind;
  assign out_token_char    = head.token_char;
  assign out_token_number  = head.token_number;
  assign out_char_offset   = head.char_offset;
  assign out_cursor_token  = head.cursor_token;
  assign out_cursor_offset = head.cursor_offset;
  assign out_cursor_placed = head.cursor_placed;
  assign out_run_last      = head.run_last;

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == K_SUMMARY |-> out_run_last)
    else $error("summary not marked as last result");

  a_char_unplaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == K_CHAR |-> !out_cursor_placed)
    else $error("cursor flag set on token character");

  a_end_unplaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == K_END |-> !out_cursor_placed && out_cursor_token == 8'd0)
    else $error("cursor fields set on token end");

endmodule

FILE: sim/quoted_command_line_tokenizer_tb.sv
// Self-checking testbench for the quoted command-line tokenizer: directed and random lines.
`timescale 1ns / 1ps

module quoted_command_line_tokenizer_tb;
  import qclt_pkg::*;

  localparam int TB_LINE_BYTES = LINE_BYTES_DEF;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 20;

  typedef struct {
    logic [7:0] line_byte;
    bit         present;
    bit         last;
    logic [7:0] cursor;
  } line_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_line_byte = 8'h00;
  logic       in_byte_present = 1'b0;
  logic       in_line_last = 1'b0;
  logic [7:0] in_cursor_position = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_item_kind;
  logic [7:0] out_token_char;
  logic [7:0] out_token_number;
  logic [7:0] out_char_offset;
  logic [7:0] out_cursor_token;
  logic [7:0] out_cursor_offset;
  logic       out_cursor_placed;
  logic       out_run_last;

  line_beat_t line_beats[$];
  res_t       token_items_due[$];
  res_t       beat_res[RES_MAX];
  int         beat_res_n;
  int         beats_queued = 0;
  int         send_pct = 0;
  int         recv_pct = 0;
  int         errors = 0;
  int         quiet_cycles = 0;
  bit         in_taken = 1'b0;
  bit         out_taken = 1'b0;

  quote_t quote_open;
  quote_t quote_just_closed;
  int     tok_len;
  int     tok_count;
  int     line_pos;
  int     cur_tok;
  int     cur_off;
  bit     cur_hit;
  int     prev_tok_len;

  quoted_command_line_tokenizer #(.LINE_BYTES(TB_LINE_BYTES)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_line_byte      (in_line_byte),
    .in_byte_present   (in_byte_present),
    .in_line_last      (in_line_last),
    .in_cursor_position(in_cursor_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item_kind     (out_item_kind),
    .out_token_char    (out_token_char),
    .out_token_number  (out_token_number),
    .out_char_offset   (out_char_offset),
    .out_cursor_token  (out_cursor_token),
    .out_cursor_offset (out_cursor_offset),
    .out_cursor_placed (out_cursor_placed),
    .out_run_last      (out_run_last)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic flag_mismatch(string what);
    if (errors < 40) $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic logic [7:0] sat8(int v);
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  task automatic clear_line();
    quote_open        = Q_NONE;
    quote_just_closed = Q_NONE;
    tok_len           = 0;
    tok_count         = 0;
    line_pos          = 0;
    cur_tok           = 0;
    cur_off           = 0;
    cur_hit           = 1'b0;
    prev_tok_len      = 0;
  endtask

  task automatic push_res(item_kind_t kind, logic [7:0] ch, int tn, int off, int ct, int co,
                          bit cp);
    res_t r;
    r.item_kind     = kind;
    r.token_char    = ch;
    r.token_number  = sat8(tn);
    r.char_offset   = sat8(off);
    r.cursor_token  = sat8(ct);
    r.cursor_offset = sat8(co);
    r.cursor_placed = cp;
    r.run_last      = 1'b0;
    beat_res[beat_res_n] = r;
    beat_res_n++;
  endtask

  task automatic note_cursor(int cursor);
    if (cursor == line_pos) begin
      cur_hit = 1'b1;
      cur_tok = tok_count;
      cur_off = tok_len;
    end
  endtask

  task automatic keep_char(logic [7:0] ch, int cursor);
    note_cursor(cursor);
    push_res(K_CHAR, ch, tok_count, tok_len, 0, 0, 1'b0);
    tok_len++;
  endtask

  task automatic close_token();
    if (tok_len != 0) begin
      push_res(K_END, 8'h00, tok_count, tok_len, 0, 0, 1'b0);
      prev_tok_len = tok_len;
      tok_count++;
      tok_len = 0;
    end
  endtask

  task automatic tokenize_beat(logic [7:0] ch, bit present, bit last, logic [7:0] cursor_b);
    quote_t q;
    int     cursor;
    int     ct;
    int     co;
    bit     cp;
    cursor = int'(cursor_b);
    beat_res_n = 0;
    q = (ch == CH_DQUOTE) ? Q_DOUBLE : (ch == CH_SQUOTE) ? Q_SINGLE : Q_NONE;
    if (present && line_pos < TB_LINE_BYTES) begin
      if (quote_open != Q_NONE && quote_open != q) begin
        keep_char(ch, cursor);
      end else if (quote_open != Q_NONE) begin
        quote_just_closed = quote_open;
        quote_open = Q_NONE;
      end else if (q != Q_NONE) begin
        if (quote_just_closed == q) keep_char(ch, cursor);
        quote_open = q;
      end else begin
        quote_just_closed = Q_NONE;
        if (ch == CH_SPACE) close_token();
        else keep_char(ch, cursor);
      end
      line_pos++;
    end
    if (last) begin
      close_token();
      if (cursor >= line_pos) begin
        ct = (tok_count == 0) ? 0 : tok_count - 1;
        co = (tok_count == 0) ? 0 : prev_tok_len;
        cp = 1'b1;
      end else if (cur_hit) begin
        ct = cur_tok;
        co = cur_off;
        cp = 1'b1;
      end else begin
        ct = 0;
        co = 0;
        cp = 1'b0;
      end
      push_res(K_SUMMARY, 8'h00, tok_count, 0, ct, co, cp);
      clear_line();
    end
    if (beat_res_n > 0) beat_res[beat_res_n - 1].run_last = 1'b1;
    for (int i = 0; i < beat_res_n; i++) begin
      token_items_due.insert(token_items_due.size(), beat_res[i]);
    end
  endtask

  task automatic add_beat(logic [7:0] ch, bit present, bit last, logic [7:0] cursor);
    line_beat_t b;
    b.line_byte = ch;
    b.present   = present;
    b.last      = last;
    b.cursor    = cursor;
    line_beats.insert(line_beats.size(), b);
    beats_queued++;
  endtask

  task automatic queue_line(int len);
    logic [7:0] ch;
    logic [7:0] cur;
    int         pick;
    int         top;
    bit         marker_end;
    bit         present;
    top = (len + 2 > 255) ? 255 : len + 2;
    cur = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, top)) : 8'($urandom_range(0, 255));
    marker_end = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      present = 1'b1;
      if (pick < 45) ch = 8'(8'h61 + $urandom_range(0, 25));
      else if (pick < 62) ch = CH_SPACE;
      else if (pick < 72) ch = CH_DQUOTE;
      else if (pick < 82) ch = CH_SQUOTE;
      else begin
        ch = 8'($urandom_range(0, 255));
        present = (pick < 94);
      end
      add_beat(ch, present, !marker_end && (i == len - 1), cur);
    end
    if (marker_end) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, cur);
  endtask

  task automatic queue_lines(int target);
    while (beats_queued < target) begin
      if ($urandom_range(0, 7) == 0) queue_line($urandom_range(13, 40));
      else queue_line($urandom_range(0, 12));
    end
  endtask

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (line_beats.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
        in_line_byte       <= line_beats[0].line_byte;
        in_byte_present    <= line_beats[0].present;
        in_line_last       <= line_beats[0].last;
        in_cursor_position <= line_beats[0].cursor;
        in_valid           <= 1'b1;
        void'(line_beats.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_pct);
  end

  always @(posedge clk) begin : monitor
    res_t want;
    if (rst_n) begin
      in_taken  = in_valid && !in_stall;
      out_taken = out_valid && !out_stall;
      if (out_taken) begin
        if (token_items_due.size() == 0) begin
          flag_mismatch("result beat with nothing pending");
        end else begin
          want = token_items_due.pop_front();
          check_field("item_kind", out_item_kind, want.item_kind);
          check_field("token_char", out_token_char, want.token_char);
          check_field("token_number", out_token_number, want.token_number);
          check_field("char_offset", out_char_offset, want.char_offset);
          check_field("cursor_token", out_cursor_token, want.cursor_token);
          check_field("cursor_offset", out_cursor_offset, want.cursor_offset);
          check_field("cursor_placed", out_cursor_placed, want.cursor_placed);
          check_field("run_last", out_run_last, want.run_last);
        end
      end
      if (in_taken) begin
        tokenize_beat(in_line_byte, in_byte_present, in_line_last, in_cursor_position);
      end
      if (in_taken || out_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("quoted_command_line_tokenizer_tb: errors");
        $finish;
      end
    end else begin
      in_taken  = 1'b0;
      out_taken = 1'b0;
    end
  end

  initial begin
    clear_line();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_beat(8'h61, 1'b1, 1'b0, 8'd1);
    add_beat(8'h62, 1'b1, 1'b0, 8'd1);
    add_beat(CH_SPACE, 1'b1, 1'b0, 8'd1);
    add_beat(8'h63, 1'b1, 1'b1, 8'd1);

    add_beat(CH_SQUOTE, 1'b1, 1'b0, 8'd200);
    add_beat(8'h61, 1'b1, 1'b0, 8'd200);
    add_beat(CH_SPACE, 1'b1, 1'b0, 8'd200);
    add_beat(CH_DQUOTE, 1'b1, 1'b0, 8'd200);
    add_beat(CH_SQUOTE, 1'b1, 1'b0, 8'd200);
    add_beat(CH_SQUOTE, 1'b1, 1'b0, 8'd200);
    add_beat(8'h78, 1'b1, 1'b0, 8'd200);
    add_beat(8'h00, 1'b0, 1'b1, 8'd200);

    add_beat(CH_SPACE, 1'b1, 1'b0, 8'd255);
    add_beat(8'hAA, 1'b0, 1'b0, 8'd255);
    add_beat(CH_SPACE, 1'b1, 1'b1, 8'd255);

    add_beat(CH_DQUOTE, 1'b1, 1'b0, 8'd0);
    add_beat(CH_DQUOTE, 1'b1, 1'b0, 8'd0);
    add_beat(CH_SPACE, 1'b1, 1'b0, 8'd0);
    add_beat(8'h00, 1'b1, 1'b0, 8'd0);
    add_beat(8'hFF, 1'b1, 1'b1, 8'd0);

    add_beat(8'h55, 1'b0, 1'b1, 8'd0);

    queue_lines(beats_queued + 45);
    wait (line_beats.size() == 0);

    send_pct = 64;
    queue_lines(beats_queued + 45);
    wait (line_beats.size() == 0 && !in_valid && token_items_due.size() == 0);

    send_pct = 0;
    recv_pct = 64;
    queue_line(300);
    queue_lines(beats_queued + 45);
    wait (line_beats.size() == 0);

    send_pct = 28;
    recv_pct = 28;
    queue_lines(beats_queued + 45);
    wait (line_beats.size() == 0 && !in_valid && token_items_due.size() == 0);

    send_pct = 0;
    recv_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("quoted_command_line_tokenizer_tb: clean");
    end else begin
      $display("quoted_command_line_tokenizer_tb: errors");
    end
    $finish;
  end

endmodule
